// ===== src/assert_macros.svh =====
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// property that must hold at every clock edge outside reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// property checked during reset too
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

// ===== src/css_pkg.sv =====
// shared types and constants for the cell stack statistics unit
// no dependencies
`timescale 1ns / 1ps
package css_pkg;
   localparam int MAX_LAYERS_DEF = 64;
   localparam int SUM_W = 38;
   localparam int SQ_W  = 54;
   localparam int CNT_W = 7;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [2:0] OP_MAX   = 3'd0;
   localparam logic [2:0] OP_MIN   = 3'd1;
   localparam logic [2:0] OP_MEAN  = 3'd2;
   localparam logic [2:0] OP_STD   = 3'd3;
   localparam logic [2:0] OP_RANGE = 3'd4;

   localparam logic [0:0] REG_OP_MODE = 1'b0;
   localparam logic [0:0] REG_NODATA  = 1'b1;

   localparam logic [31:0] NODATA_RESET = 32'hD8F10000;
   localparam logic signed [31:0] POS_SAT = 32'sh7FFFFFFF;

   typedef struct packed {
      logic signed [31:0] sample;
      logic               last_layer;
   } req_type;

   typedef struct packed {
      logic signed [31:0] cell_value;
      logic               nodata_hit;
   } rsp_type;

   // finished cell handed from the front to the back
   typedef struct packed {
      logic signed [31:0]      max_v;
      logic signed [31:0]      min_v;
      logic signed [SUM_W-1:0] sum;
      logic [SQ_W-1:0]         sum_sq;
      logic [CNT_W-1:0]        count;
      logic                    nodata;
   } cell_type;
endpackage

// ===== src/css_front.sv =====
// front end: accumulates the samples of one cell and emits a cell record
// depends on css_pkg
`timescale 1ns / 1ps
module css_front #(
   parameter int MAX_LAYERS = css_pkg::MAX_LAYERS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  css_pkg::req_type  req_data,
   input  logic [31:0]       nodata_value,
   output logic              cell_valid,
   input  logic              cell_ready,
   output css_pkg::cell_type cell_data
);
   // state: 0 accumulate, 1 square, 2 hand off
   localparam logic [1:0] ST_ACC = 2'd0;
   localparam logic [1:0] ST_SQ  = 2'd1;
   localparam logic [1:0] ST_OUT = 2'd2;

   logic [1:0]  state_ff, state_in;
   logic signed [31:0] max_ff, max_in, min_ff, min_in;
   logic signed [css_pkg::SUM_W-1:0] sum_ff, sum_in;
   logic [css_pkg::SQ_W-1:0] sq_ff, sq_in;
   logic [css_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic nd_ff, nd_in;
   logic [31:0] abs_ff, abs_in;
   logic take_ff, take_in;
   logic last_ff, last_in;
   logic [63:0] prod;
   logic signed [31:0] s;
   logic in_ok;

   assign s = req_data.sample;
   assign req_ready = (state_ff == ST_ACC);
   assign cell_valid = (state_ff == ST_OUT);
   assign in_ok = 32'(cnt_ff) < MAX_LAYERS;
   assign prod = 64'(abs_ff) * 64'(abs_ff);

   always_comb begin
      cell_data.max_v = max_ff;
      cell_data.min_v = min_ff;
      cell_data.sum = sum_ff;
      cell_data.sum_sq = sq_ff;
      cell_data.count = cnt_ff;
      cell_data.nodata = nd_ff;
   end

   // accumulate in ST_ACC, square in ST_SQ, hand off the cell in ST_OUT
   always_comb begin
      state_in = state_ff;
      max_in = max_ff; min_in = min_ff; sum_in = sum_ff; sq_in = sq_ff;
      cnt_in = cnt_ff; nd_in = nd_ff; abs_in = abs_ff; take_in = take_ff;
      last_in = last_ff;
      unique case (state_ff)
         ST_ACC: begin
            if (req_valid) begin
               if (req_data.sample == nodata_value) nd_in = 1'b1;
               take_in = in_ok;
               last_in = req_data.last_layer;
               abs_in = s[31] ? 32'(-s) : 32'(s);
               if (in_ok) begin
                  if (cnt_ff == '0 || s > max_ff) max_in = s;
                  if (cnt_ff == '0 || s < min_ff) min_in = s;
                  sum_in = sum_ff + css_pkg::SUM_W'(s);
                  cnt_in = cnt_ff + 1'b1;
               end
               state_in = ST_SQ;
            end
         end
         ST_SQ: begin
            if (take_ff) sq_in = sq_ff + css_pkg::SQ_W'(prod >> 16);
            state_in = last_ff ? ST_OUT : ST_ACC;
         end
         ST_OUT: begin
            if (cell_ready) begin
               state_in = ST_ACC;
               max_in = '0; min_in = '0; sum_in = '0; sq_in = '0;
               cnt_in = '0; nd_in = 1'b0;
            end
         end
         default: state_in = ST_ACC;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_ACC;
         max_ff <= '0; min_ff <= '0; sum_ff <= '0; sq_ff <= '0;
         cnt_ff <= '0; nd_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         max_ff <= max_in; min_ff <= min_in; sum_ff <= sum_in; sq_ff <= sq_in;
         cnt_ff <= cnt_in; nd_ff <= nd_in;
      end
      abs_ff <= abs_in;
      take_ff <= take_in;
      last_ff <= last_in;
   end
endmodule

// ===== src/css_queue.sv =====
// two-entry queue of finished cells between front and back
// depends on css_pkg
`timescale 1ns / 1ps
module css_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  css_pkg::cell_type in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output css_pkg::cell_type out_data
);
   css_pkg::cell_type mem_ff [css_pkg::QUEUE_DEPTH];
   logic wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic push, pop;

   assign in_ready = cnt_ff != 2'd2;
   assign out_valid = cnt_ff != 2'd0;
   assign out_data = mem_ff[rp_ff];
   assign push = in_valid && in_ready;
   assign pop = out_valid && out_ready;

   // pointers and fill count
   always_comb begin
      wp_in = push ? ~wp_ff : wp_ff;
      rp_in = pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0; rp_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         wp_ff <= wp_in; rp_ff <= rp_in; cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wp_ff] <= in_data;
   end
endmodule

// ===== src/css_back.sv =====
// back end: divides, takes the square root and picks the statistic
// depends on css_pkg
`timescale 1ns / 1ps
module css_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              cell_valid,
   output logic              cell_ready,
   input  css_pkg::cell_type cell_data,
   input  logic [2:0]        op_mode,
   input  logic [31:0]       nodata_value,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output css_pkg::rsp_type  rsp_data
);
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_DIV  = 3'd1;
   localparam logic [2:0] ST_M2   = 3'd2;
   localparam logic [2:0] ST_SQRT = 3'd3;
   localparam logic [2:0] ST_FIN  = 3'd4;
   localparam logic [2:0] ST_OUT  = 3'd5;

   localparam int QW = css_pkg::SQ_W;   // shared divider width

   logic [2:0] state_ff, state_in;
   css_pkg::cell_type c_ff, c_in;
   logic [5:0] step_ff, step_in;
   // two restoring dividers: quotients in q1/q2, remainders in r1/r2
   logic [QW-1:0] q1_ff, q1_in, q2_ff, q2_in;
   logic [css_pkg::CNT_W-1:0] r1_ff, r1_in, r2_ff, r2_in;
   logic [css_pkg::CNT_W-1:0] n;
   logic [css_pkg::CNT_W:0] t1, t2;
   logic [63:0] m2_ff, m2_in;
   // square root: 35-bit result of a 70-bit value, one bit per cycle
   logic [69:0] rem_ff, rem_in, v_ff, v_in;
   logic [34:0] root_ff, root_in;
   logic [71:0] trial;
   logic signed [31:0] res_ff, res_in;
   logic hit_ff, hit_in;
   logic [37:0] sabs, mean_abs;
   logic signed [37:0] mean;
   logic signed [32:0] range;

   assign n = (c_ff.count == '0) ? css_pkg::CNT_W'(1) : c_ff.count;
   assign cell_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);
   assign rsp_data.cell_value = res_ff;
   assign rsp_data.nodata_hit = hit_ff;
   assign sabs = c_ff.sum[37] ? 38'(-c_ff.sum) : 38'(c_ff.sum);
   assign mean_abs = 38'(q1_ff);
   assign mean = c_ff.sum[37] ? -$signed(mean_abs) : $signed(mean_abs);
   assign range = 33'(c_ff.max_v) - 33'(c_ff.min_v);
   assign t1 = {r1_ff, q1_ff[QW-1]} ;
   assign t2 = {r2_ff, q2_ff[QW-1]};
   assign trial = {rem_ff, v_ff[69:68]} - {35'd0, root_ff, 2'b01};

   always_comb begin
      state_in = state_ff; c_in = c_ff; step_in = step_ff;
      q1_in = q1_ff; r1_in = r1_ff; q2_in = q2_ff; r2_in = r2_ff;
      m2_in = m2_ff; rem_in = rem_ff; v_in = v_ff; root_in = root_ff;
      res_in = res_ff; hit_in = hit_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cell_valid) begin
               c_in = cell_data;
               state_in = ST_DIV;
               step_in = '0;
               q1_in = '0; r1_in = '0; q2_in = '0; r2_in = '0;
            end
         end
         ST_DIV: begin
            // two restoring dividers in lockstep, one quotient bit per cycle
            if (step_ff == '0) begin
               q1_in = QW'(sabs);
               q2_in = c_ff.sum_sq;
               step_in = 6'd1;
            end else begin
               if (t1 >= {1'b0, n}) begin
                  r1_in = css_pkg::CNT_W'(t1 - {1'b0, n});
                  q1_in = {q1_ff[QW-2:0], 1'b1};
               end else begin
                  r1_in = css_pkg::CNT_W'(t1);
                  q1_in = {q1_ff[QW-2:0], 1'b0};
               end
               if (t2 >= {1'b0, n}) begin
                  r2_in = css_pkg::CNT_W'(t2 - {1'b0, n});
                  q2_in = {q2_ff[QW-2:0], 1'b1};
               end else begin
                  r2_in = css_pkg::CNT_W'(t2);
                  q2_in = {q2_ff[QW-2:0], 1'b0};
               end
               if (step_ff == 6'(QW)) state_in = ST_M2;
               else step_in = step_ff + 1'b1;
            end
         end
         ST_M2: begin
            // mean squared, saturated when the mean exceeds 32 bits; variance and root setup follow in ST_SQRT
            m2_in = (64'(mean_abs[31:0]) * 64'(mean_abs[31:0])) >> 16;
            if (mean_abs[37:32] != '0) m2_in = '1;
            state_in = ST_SQRT;
            step_in = '0;
         end
         ST_SQRT: begin
            if (step_ff == '0) begin
               v_in = (64'(q2_ff) > m2_ff) ? {6'd0, 64'(q2_ff) - m2_ff} << 16 : '0;
               rem_in = '0; root_in = '0;
               step_in = 6'd1;
            end else begin
               if (!trial[71]) begin
                  rem_in = trial[69:0];
                  root_in = {root_ff[33:0], 1'b1};
               end else begin
                  rem_in = {rem_ff[67:0], v_ff[69:68]};
                  root_in = {root_ff[33:0], 1'b0};
               end
               v_in = {v_ff[67:0], 2'b00};
               if (step_ff == 6'd35) state_in = ST_FIN;
               else step_in = step_ff + 1'b1;
            end
         end
         ST_FIN: begin
            hit_in = c_ff.nodata;
            unique case (op_mode)
               css_pkg::OP_MAX:  res_in = c_ff.max_v;
               css_pkg::OP_MIN:  res_in = c_ff.min_v;
               css_pkg::OP_MEAN: res_in = 32'(mean);
               css_pkg::OP_STD:
                  res_in = (root_ff[34:31] != '0) ? css_pkg::POS_SAT : 32'(root_ff);
               css_pkg::OP_RANGE:
                  res_in = range[32] ? 32'(range) :
                           (range[31] ? css_pkg::POS_SAT : 32'(range));
               default: res_in = nodata_value;
            endcase
            if (c_ff.nodata) res_in = nodata_value;
            state_in = ST_OUT;
         end
         ST_OUT: if (rsp_ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
      c_ff <= c_in; step_ff <= step_in;
      q1_ff <= q1_in; r1_ff <= r1_in; q2_ff <= q2_in; r2_ff <= r2_in;
      m2_ff <= m2_in; rem_ff <= rem_in; v_ff <= v_in; root_ff <= root_in;
      res_ff <= res_in; hit_ff <= hit_in;
   end
endmodule

// ===== src/cell_stack_statistics_unit.sv =====
// per-cell stack statistics: the front end accumulates a sample, then squares it,
// before it takes the next, and hands off a cell record after a cell's last layer
// the back end divides and takes the square root of one cell at a time, and a
// two-entry queue between them lets the front end go on while the back end is busy
// synchronous active-high reset clears accumulators, queue pointers, states and CSRs
`timescale 1ns / 1ps
module cell_stack_statistics_unit #(
   parameter int MAX_LAYERS = css_pkg::MAX_LAYERS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  css_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output css_pkg::rsp_type rsp_data,
   input  logic             csr_psel,
   input  logic             csr_penable,
   input  logic             csr_pwrite,
   input  logic [2:0]       csr_paddr,
   input  logic [31:0]      csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   logic [2:0]  op_ff;
   logic [31:0] nd_ff;
   logic f_valid, f_ready, b_valid, b_ready;
   css_pkg::cell_type f_data, b_data;

   assign csr_pready = 1'b1;

   // register transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff <= css_pkg::OP_MAX;
         nd_ff <= css_pkg::NODATA_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         case (csr_paddr[2])
            css_pkg::REG_OP_MODE: op_ff <= csr_pwdata[2:0];
            default:              nd_ff <= csr_pwdata;
         endcase
      end
   end

   always_comb begin
      csr_prdata = '0;
      case (csr_paddr[2])
         css_pkg::REG_OP_MODE: csr_prdata = {29'd0, op_ff};
         default:              csr_prdata = nd_ff;
      endcase
   end

   css_front #(.MAX_LAYERS(MAX_LAYERS)) u_front (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .nodata_value(nd_ff),
      .cell_valid(f_valid), .cell_ready(f_ready), .cell_data(f_data)
   );

   css_queue u_queue (
      .clock, .reset,
      .in_valid(f_valid), .in_ready(f_ready), .in_data(f_data),
      .out_valid(b_valid), .out_ready(b_ready), .out_data(b_data)
   );

   css_back u_back (
      .clock, .reset,
      .cell_valid(b_valid), .cell_ready(b_ready), .cell_data(b_data),
      .op_mode(op_ff), .nodata_value(nd_ff),
      .rsp_valid, .rsp_ready, .rsp_data
   );
endmodule

// ===== src/css_checker.sv =====
// port-level checks of the cell stack statistics unit, bound to the top
// depends on css_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"
module css_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input css_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input css_pkg::rsp_type rsp_data,
   input logic             csr_pready
);
   logic req_stall, rsp_stall;

   assign req_stall = req_valid && !req_ready;
   assign rsp_stall = rsp_valid && !rsp_ready;

   // waiting transfers hold their payload
   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_stall |=> rsp_valid && $stable(rsp_data), "rsp not held")
   `ASSERT_CLK(a_req_hold, clock, reset, req_stall |=> req_valid && $stable(req_data), "req not held")
   // port behavior over time
   `ASSERT_ALWAYS(a_pready, clock, csr_pready, "pready low")
   `ASSERT_CLK(a_no_back, clock, reset, req_valid && req_ready |=> !req_ready, "two samples in a row")
   `ASSERT_ALWAYS(a_reset_quiet, clock, $past(reset) |-> !rsp_valid, "result right after reset")
endmodule

bind cell_stack_statistics_unit css_checker u_css_checker (
   .clock, .reset, .req_valid, .req_ready, .req_data,
   .rsp_valid, .rsp_ready, .rsp_data, .csr_pready
);
